// ===== rtl/core/ftpc_pkg.sv =====
`timescale 1ns / 1ps

package ftpc_pkg;

    // Default table depth.
    localparam int TABLE_ENTRIES_DEFAULT = 256;

    // Field widths.
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int COUNT_W = 32;
    localparam int RIDX_W  = 8;

    // Saturation value of a packet count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes.
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Flow key: the four tuple fields.
    typedef struct packed {
        logic [IP_W-1:0]   sip;
        logic [IP_W-1:0]   dip;
        logic [PORT_W-1:0] sport;
        logic [PORT_W-1:0] dport;
    } flow_key_t;

    // One table entry as stored in memory.
    typedef struct packed {
        flow_key_t          key;
        logic [COUNT_W-1:0] count;
    } flow_entry_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_DONE
    } ftpc_state_t;

endpackage

// ===== rtl/core/ftpc_table.sv =====
`timescale 1ns / 1ps

module ftpc_table
    import ftpc_pkg::*;
#(
    parameter int DEPTH  = TABLE_ENTRIES_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output flow_entry_t       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  flow_entry_t       wr_data
);

    // Entry storage: keys and counts side by side.
    flow_entry_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data follows rd_en in the next cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/flow_tuple_packet_counter_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   opcode src_ip dst_ip src_l4_port dst_l4_port read_index
// out      output     out_valid/out_stall entry_index found dropped key_* packet_count
//
// One item is in work at a time. A count item scans at most the used entries,
// fewer on an early match: the scan reads one stored entry per cycle from the
// table memory, pipelined against its registered read port, and the cycle that
// checks the last entry read also writes the entry back. A read item passes
// through S_RD_ISSUE, S_RD_WAIT and S_DONE, skipping S_RD_WAIT when the index is past the used entries.
// Reset empties the table at once through the fill count; memory contents need
// no clearing. A stalled result waits in the output register while the next
// item is accepted and worked on; that item then waits until the register frees.

module flow_tuple_packet_counter_unit
    import ftpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [IP_W-1:0]    src_ip,
    input  logic [IP_W-1:0]    dst_ip,
    input  logic [PORT_W-1:0]  src_l4_port,
    input  logic [PORT_W-1:0]  dst_l4_port,
    input  logic [RIDX_W-1:0]  read_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [RIDX_W-1:0]  entry_index,
    output logic               found,
    output logic               dropped,
    output logic [IP_W-1:0]    key_src_ip,
    output logic [IP_W-1:0]    key_dst_ip,
    output logic [PORT_W-1:0]  key_src_l4_port,
    output logic [PORT_W-1:0]  key_dst_l4_port,
    output logic [COUNT_W-1:0] packet_count
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
    localparam logic [CNT_W-1:0] USED_FULL = CNT_W'(TABLE_ENTRIES);

    // Control state.
    ftpc_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;

    // Item and result payload.
    flow_key_t          key_reg, key_next;
    logic [RIDX_W-1:0]  ri_reg, ri_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [RIDX_W-1:0]  res_idx_reg, res_idx_next;
    logic               res_found_reg, res_found_next;
    logic               res_drop_reg, res_drop_next;
    flow_entry_t        res_entry_reg, res_entry_next;
    logic [RIDX_W-1:0]  o_idx_reg, o_idx_next;
    logic               o_found_reg, o_found_next;
    logic               o_drop_reg, o_drop_next;
    flow_entry_t        o_entry_reg, o_entry_next;

    // Table memory port signals.
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    flow_entry_t        mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    flow_entry_t        mem_wr_data;

    // Decoded conditions.
    logic               accept;
    logic               hit;
    logic               scan_more;
    logic               rd_in_range;
    logic               out_free;
    logic [COUNT_W-1:0] count_inc;

    ftpc_table #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Handshake and compare terms.
    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign hit         = pend_reg && (mem_rd_data.key == key_reg);
    assign scan_more   = (scan_ptr_reg < used_reg);
    assign rd_in_range = (CMP_W'(ri_reg) < CMP_W'(used_reg));
    assign out_free    = !out_valid_reg || !out_stall;
    assign count_inc   = (mem_rd_data.count == COUNT_MAX) ? COUNT_MAX
                                                          : mem_rd_data.count + 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (opcode == OP_READ) ? S_RD_ISSUE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit || !scan_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_ISSUE:
            begin
                state_next = rd_in_range ? S_RD_WAIT : S_DONE;
            end
            S_RD_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and result staging.
    always_comb
    begin
        used_next      = used_reg;
        scan_ptr_next  = scan_ptr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        key_next       = key_reg;
        ri_next        = ri_reg;
        res_idx_next   = res_idx_reg;
        res_found_next = res_found_reg;
        res_drop_next  = res_drop_reg;
        res_entry_next = res_entry_reg;
        o_idx_next     = o_idx_reg;
        o_found_next   = o_found_reg;
        o_drop_next    = o_drop_reg;
        o_entry_next   = o_entry_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = scan_ptr_reg[IDX_W-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = pend_idx_reg;
        mem_wr_data    = '{key: key_reg, count: count_inc};

        case (state_reg)
            S_IDLE:
            begin
                // Capture the beat and restart the scan.
                if (accept)
                begin
                    key_next      = '{sip: src_ip, dip: dst_ip,
                                      sport: src_l4_port, dport: dst_l4_port};
                    ri_next       = read_index;
                    scan_ptr_next = '0;
                    pend_next     = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    // Matched flow: bump the count and write it back.
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = pend_idx_reg;
                    mem_wr_data    = '{key: mem_rd_data.key, count: count_inc};
                    res_idx_next   = RIDX_W'(pend_idx_reg);
                    res_found_next = 1'b1;
                    res_drop_next  = 1'b0;
                    res_entry_next = '{key: mem_rd_data.key, count: count_inc};
                    pend_next      = 1'b0;
                end
                else if (scan_more)
                begin
                    // Issue the next entry; its data is checked next cycle.
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = scan_ptr_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_ptr_reg[IDX_W-1:0];
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                end
                else if (used_reg != USED_FULL)
                begin
                    // New flow: append at the next free index.
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = used_reg[IDX_W-1:0];
                    mem_wr_data    = '{key: key_reg, count: COUNT_W'(1)};
                    res_idx_next   = RIDX_W'(used_reg[IDX_W-1:0]);
                    res_found_next = 1'b0;
                    res_drop_next  = 1'b0;
                    res_entry_next = '{key: key_reg, count: COUNT_W'(1)};
                    used_next      = used_reg + 1'b1;
                    pend_next      = 1'b0;
                end
                else
                begin
                    // Table full: the new flow is refused.
                    res_idx_next   = '0;
                    res_found_next = 1'b0;
                    res_drop_next  = 1'b1;
                    res_entry_next = '{key: key_reg, count: '0};
                    pend_next      = 1'b0;
                end
            end
            S_RD_ISSUE:
            begin
                res_idx_next   = ri_reg;
                res_found_next = 1'b0;
                res_drop_next  = 1'b0;
                res_entry_next = '0;
                if (rd_in_range)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(ri_reg);
                end
            end
            S_RD_WAIT:
            begin
                res_found_next = 1'b1;
                res_entry_next = mem_rd_data;
            end
            S_DONE:
            begin
                // Move the result into the output register once it is free.
                if (out_free)
                begin
                    o_idx_next     = res_idx_reg;
                    o_found_next   = res_found_reg;
                    o_drop_next    = res_drop_reg;
                    o_entry_next   = res_entry_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            scan_ptr_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            scan_ptr_reg  <= scan_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        ri_reg        <= ri_next;
        pend_idx_reg  <= pend_idx_next;
        res_idx_reg   <= res_idx_next;
        res_found_reg <= res_found_next;
        res_drop_reg  <= res_drop_next;
        res_entry_reg <= res_entry_next;
        o_idx_reg     <= o_idx_next;
        o_found_reg   <= o_found_next;
        o_drop_reg    <= o_drop_next;
        o_entry_reg   <= o_entry_next;
    end

    // Output beat.
    assign out_valid       = out_valid_reg;
    assign entry_index     = o_idx_reg;
    assign found           = o_found_reg;
    assign dropped         = o_drop_reg;
    assign key_src_ip      = o_entry_reg.key.sip;
    assign key_dst_ip      = o_entry_reg.key.dip;
    assign key_src_l4_port = o_entry_reg.key.sport;
    assign key_dst_l4_port = o_entry_reg.key.dport;
    assign packet_count    = o_entry_reg.count;

endmodule
